[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers, sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property
`define LLRE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same-cycle implication
`define LLRE_ASSERT_IMPLY(lbl, ante, cons, msg) \
  `LLRE_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define LLRE_ASSERT_NEXT(lbl, ante, cons, msg) \
  `LLRE_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[hw/rtl/llre_pkg.sv]
// ----------------------------------------------------------------------------
// llre_pkg
// Shared widths, mode codes, controller commands and status for the engine.
// ----------------------------------------------------------------------------
package llre_pkg;

  localparam int unsigned MODE_W = 3;
  localparam int unsigned ITEM_W = 10;
  localparam int unsigned SUM_W  = 19;

  localparam logic [MODE_W-1:0] MODE_INIT        = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MOVE_BEFORE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_MOVE_AFTER  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SWAP        = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVERSE     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REPORT      = 3'd5;

  localparam logic [ITEM_W-1:0] COUNT_RESET = 10'd1023;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_TOGGLE,
    CMD_RD_X,
    CMD_RD_Y,
    CMD_PLAN,
    CMD_JOIN,
    CMD_INIT,
    CMD_RPT_STEP,
    CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              cmd_ok;
    logic              cnt_last;
    logic              join_done;
    logic              out_free;
  } stat_t;

endpackage

[hw/rtl/linked_list_reorder_engine_unit.sv]
// ---------------------------------------------------------------------------------------------
// linked_list_reorder_engine_unit: circular doubly linked list held in two link memories.
// Move and swap relink through up to four joins; reverse only toggles the direction flag.
// Throughput: one word at a time; init and report walk one link per cycle through the memories.
// Reset: synchronous rst_n; count 1023, flag clear, links undefined until an init word runs.
// ---------------------------------------------------------------------------------------------
`include "assert_macros.svh"

module linked_list_reorder_engine_unit #(
  parameter int unsigned MAX_ITEMS = 1023
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: item_count
  input  logic        cfg_wr_en,
  input  logic [9:0]  cfg_wr_data,
  // command words
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [2:0] mode, [12:3] first_item, [22:13] second_item, pad
  // report results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // [18:0] odd_position_sum, pad
);

  llre_pkg::cmd_t                  ctl_cmd;
  llre_pkg::stat_t                 ctl_stat;
  logic [llre_pkg::SUM_W-1:0]      out_sum;

  // Controller: takes a word only in its idle state, then sequences the
  // relink (two link reads, a plan, then one join per cycle), the init
  // sweep, or the report walk.
  llre_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (ctl_stat),
    .cmd      (ctl_cmd)
  );

  // Datapath: prev and next link memories, each one write and one registered
  // read per cycle; a join writes next[a] and prev[b] in the same cycle.
  // The result register sits between the walk and the output channel, so a
  // new word is taken while a report result still waits.
  llre_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_mode     (in_tdata[2:0]),
    .in_first    (in_tdata[12:3]),
    .in_second   (in_tdata[22:13]),
    .cmd         (ctl_cmd),
    .stat        (ctl_stat),
    .out_valid   (out_tvalid),
    .out_sum     (out_sum),
    .out_ready   (out_tready)
  );

  assign out_tdata = {5'b0, out_sum};

  // result is loaded only into a free output register
  `LLRE_ASSERT_IMPLY(a_emit_free, ctl_cmd == llre_pkg::CMD_EMIT, !out_tvalid || out_tready, "emit into a busy output register")
  // a taken word always leaves the idle state for dispatch
  `LLRE_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "ready held after an accepted word")
  // a result word only appears after an emit command
  `LLRE_ASSERT_IMPLY(a_rise_from_emit, $rose(out_tvalid), $past(ctl_cmd == llre_pkg::CMD_EMIT), "result without emit")

endmodule

[hw/rtl/llre_ctrl.sv]
// ----------------------------------------------------------------------------
// llre_ctrl
// Sequencer: accepts a word, dispatches on its mode and steps the datapath.
// ----------------------------------------------------------------------------
module llre_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  llre_pkg::stat_t     stat,
  output llre_pkg::cmd_t      cmd
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_DISPATCH = 8'b0000_0010,
    ST_RD_Y     = 8'b0000_0100,
    ST_PLAN     = 8'b0000_1000,
    ST_JOIN     = 8'b0001_0000,
    ST_INIT     = 8'b0010_0000,
    ST_RPT      = 8'b0100_0000,
    ST_FIN      = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = llre_pkg::CMD_NONE;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd       = llre_pkg::CMD_LOAD;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_IDLE;
        unique case (stat.mode) inside
          llre_pkg::MODE_INIT: state_nxt = ST_INIT;
          llre_pkg::MODE_MOVE_BEFORE, llre_pkg::MODE_MOVE_AFTER, llre_pkg::MODE_SWAP: begin
            if (stat.cmd_ok) begin
              cmd       = llre_pkg::CMD_RD_X;
              state_nxt = ST_RD_Y;
            end
          end
          llre_pkg::MODE_REVERSE: cmd = llre_pkg::CMD_TOGGLE;
          llre_pkg::MODE_REPORT:  state_nxt = ST_RPT;
          default:                state_nxt = ST_IDLE;
        endcase
      end
      ST_RD_Y: begin
        cmd       = llre_pkg::CMD_RD_Y;
        state_nxt = ST_PLAN;
      end
      ST_PLAN: begin
        cmd       = llre_pkg::CMD_PLAN;
        state_nxt = ST_JOIN;
      end
      ST_JOIN: begin
        if (stat.join_done) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd = llre_pkg::CMD_JOIN;
        end
      end
      ST_INIT: begin
        cmd = llre_pkg::CMD_INIT;
        if (stat.cnt_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RPT: begin
        cmd = llre_pkg::CMD_RPT_STEP;
        if (stat.cnt_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd       = llre_pkg::CMD_EMIT;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == ST_IDLE);

endmodule

[hw/rtl/llre_dpath.sv]
// ----------------------------------------------------------------------------
// llre_dpath
// Link memories, operand and join registers, walk counter and result stage.
// ----------------------------------------------------------------------------
module llre_dpath #(
  parameter int unsigned MAX_ITEMS = 1023
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [llre_pkg::ITEM_W-1:0]   cfg_wr_data,
  input  logic [llre_pkg::MODE_W-1:0]   in_mode,
  input  logic [llre_pkg::ITEM_W-1:0]   in_first,
  input  logic [llre_pkg::ITEM_W-1:0]   in_second,
  input  llre_pkg::cmd_t                cmd,
  output llre_pkg::stat_t               stat,
  output logic                          out_valid,
  output logic [llre_pkg::SUM_W-1:0]    out_sum,
  input  logic                          out_ready
);

  localparam int unsigned DEPTH = MAX_ITEMS + 1;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam logic [llre_pkg::ITEM_W-1:0] N_CAP =
    (MAX_ITEMS > 1023) ? 10'd1023 : 10'(MAX_ITEMS);

  typedef logic [IDX_W-1:0] idx_t;

  // link memories
  idx_t next_mem [DEPTH];
  idx_t prev_mem [DEPTH];
  idx_t next_q, prev_q;

  logic [llre_pkg::ITEM_W-1:0] count_r, cnt0, n_use;
  logic [llre_pkg::MODE_W-1:0] mode_r, eff_mode;
  logic [llre_pkg::ITEM_W-1:0] x_r, y_r, cnt_r;
  idx_t                        lx_r, rx_r;
  logic [3:0][IDX_W-1:0]       ja_r, jb_r, pa, pb;
  logic [2:0]                  jn_r, pn;
  logic [llre_pkg::SUM_W-1:0]  sum_r, tot_r, out_data_r;
  logic                        rev_r, out_valid_r;
  logic [20:0]                 prod;

  idx_t xi, yi, iw, ni, rd_addr, n_wa, n_wd, p_wa, p_wd;
  logic wr_en;
  logic [1:0] jk;

  // count of 0 runs as 1, anything above MAX_ITEMS (at most 1023) is capped
  always_comb begin
    cnt0  = (count_r == '0) ? 10'd1 : count_r;
    n_use = (cnt0 > N_CAP) ? N_CAP : cnt0;
  end

  assign prod = {11'b0, n_use} * ({11'b0, n_use} + 21'd1);

  assign xi = idx_t'(x_r);
  assign yi = idx_t'(y_r);
  assign iw = idx_t'(cnt_r);
  assign ni = idx_t'(n_use);
  assign jk = cnt_r[1:0];

  // status
  always_comb begin
    stat.mode      = mode_r;
    stat.cmd_ok    = (x_r != '0) && (y_r != '0) && (x_r <= n_use) && (y_r <= n_use)
                     && (x_r != y_r);
    stat.cnt_last  = (cnt_r == n_use);
    stat.join_done = (cnt_r[2:0] == jn_r);
    stat.out_free  = !out_valid_r || out_ready;
  end

  // join plan; y's links come straight off the read registers
  always_comb begin
    eff_mode = mode_r;
    if (rev_r && (mode_r == llre_pkg::MODE_MOVE_BEFORE)) begin
      eff_mode = llre_pkg::MODE_MOVE_AFTER;
    end else if (rev_r && (mode_r == llre_pkg::MODE_MOVE_AFTER)) begin
      eff_mode = llre_pkg::MODE_MOVE_BEFORE;
    end
    pa = '0;
    pb = '0;
    pn = 3'd0;
    unique case (eff_mode)
      llre_pkg::MODE_MOVE_BEFORE: begin
        if (rx_r != yi) begin
          pa[0] = lx_r;   pb[0] = rx_r;
          pa[1] = prev_q; pb[1] = xi;
          pa[2] = xi;     pb[2] = yi;
          pn    = 3'd3;
        end
      end
      llre_pkg::MODE_MOVE_AFTER: begin
        if (lx_r != yi) begin
          pa[0] = lx_r;   pb[0] = rx_r;
          pa[1] = xi;     pb[1] = next_q;
          pa[2] = yi;     pb[2] = xi;
          pn    = 3'd3;
        end
      end
      llre_pkg::MODE_SWAP: begin
        if (rx_r == yi) begin
          pa[0] = lx_r;   pb[0] = yi;
          pa[1] = yi;     pb[1] = xi;
          pa[2] = xi;     pb[2] = next_q;
          pn    = 3'd3;
        end else if (lx_r == yi) begin
          pa[0] = prev_q; pb[0] = xi;
          pa[1] = xi;     pb[1] = yi;
          pa[2] = yi;     pb[2] = rx_r;
          pn    = 3'd3;
        end else begin
          pa[0] = lx_r;   pb[0] = yi;
          pa[1] = yi;     pb[1] = rx_r;
          pa[2] = prev_q; pb[2] = xi;
          pa[3] = xi;     pb[3] = next_q;
          pn    = 3'd4;
        end
      end
      default: pn = 3'd0;
    endcase
  end

  // memory port control
  always_comb begin
    wr_en   = 1'b0;
    n_wa    = '0;
    n_wd    = '0;
    p_wa    = '0;
    p_wd    = '0;
    rd_addr = '0;
    case (cmd)
      llre_pkg::CMD_RD_X: rd_addr = xi;
      llre_pkg::CMD_RD_Y: rd_addr = yi;
      llre_pkg::CMD_RPT_STEP: rd_addr = (cnt_r == '0) ? '0 : next_q;
      llre_pkg::CMD_JOIN: begin
        wr_en = 1'b1;
        n_wa  = ja_r[jk];
        n_wd  = jb_r[jk];
        p_wa  = jb_r[jk];
        p_wd  = ja_r[jk];
      end
      llre_pkg::CMD_INIT: begin
        wr_en = 1'b1;
        n_wa  = iw;
        n_wd  = stat.cnt_last ? '0 : idx_t'(iw + idx_t'(1));
        p_wa  = iw;
        p_wd  = (cnt_r == '0) ? ni : idx_t'(iw - idx_t'(1));
      end
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      next_mem[n_wa] <= n_wd;
    end
    next_q <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prev_mem[p_wa] <= p_wd;
    end
    prev_q <= prev_mem[rd_addr];
  end

  // operand, plan and walk registers
  always_ff @(posedge clk) begin
    case (cmd)
      llre_pkg::CMD_LOAD: begin
        mode_r <= in_mode;
        x_r    <= in_first;
        y_r    <= in_second;
        cnt_r  <= '0;
        tot_r  <= prod[19:1];
      end
      llre_pkg::CMD_RD_Y: begin
        lx_r <= prev_q;
        rx_r <= next_q;
      end
      llre_pkg::CMD_PLAN: begin
        ja_r  <= pa;
        jb_r  <= pb;
        jn_r  <= pn;
        cnt_r <= '0;
      end
      llre_pkg::CMD_JOIN, llre_pkg::CMD_INIT: cnt_r <= cnt_r + 10'd1;
      llre_pkg::CMD_RPT_STEP: begin
        cnt_r <= cnt_r + 10'd1;
        if (cnt_r == '0) begin
          sum_r <= '0;
        end else if (cnt_r[0]) begin
          sum_r <= sum_r + llre_pkg::SUM_W'(next_q);
        end
      end
      llre_pkg::CMD_EMIT: begin
        out_data_r <= (rev_r && !n_use[0]) ? (tot_r - sum_r) : sum_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= llre_pkg::COUNT_RESET;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        count_r <= cfg_wr_data;
      end
      if (cmd == llre_pkg::CMD_TOGGLE) begin
        rev_r <= !rev_r;
      end else if (cmd == llre_pkg::CMD_INIT) begin
        rev_r <= 1'b0;
      end
      if (cmd == llre_pkg::CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_sum   = out_data_r;

endmodule
